// ----- rtl/reservation_station_wakeup_dispatch_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Reservation station assertion macros
// Shared property forms for the checker of the reservation station.
// ----------------------------------------------------------------------------
`ifndef RESERVATION_STATION_WAKEUP_DISPATCH_UNIT_DEFINES_SVH
`define RESERVATION_STATION_WAKEUP_DISPATCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RSWD_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("reservation station checker: same-cycle property failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define RSWD_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("reservation station checker: next-cycle property failed");

`endif

// ----- rtl/rswd_pkg.sv -----
// ----------------------------------------------------------------------------
// Reservation station package
// Widths, register indexes, entry and cell control types, unit selection.
// ----------------------------------------------------------------------------
package rswd_pkg;

	localparam int ENTRIES_DEF = 8;
	localparam int UNITS = 4;
	localparam int UNIT_W = 2;
	localparam int SRCS = 3;
	localparam int TAG_W = 6;
	localparam int CLASS_W = 3;
	localparam int MASK_W = 8;
	localparam int LIMIT_W = 4;
	localparam int LIMIT_RESET = 8;
	localparam int OCC_W = 4;
	localparam int CMP_W = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W = 8;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ISSUE = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT3 = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0] rob_tag;
		logic [CLASS_W-1:0] cls;
		logic [SRCS-1:0] wait_mask;
		logic [SRCS-1:0][TAG_W-1:0] wait_tags;
	} entry_t;

	typedef struct packed {
		logic wake;
		logic [TAG_W-1:0] bus_tag;
		logic load;
		logic shift;
		logic take_head;
	} cell_ctrl_t;

	typedef struct packed {
		logic hit;
		logic [UNIT_W-1:0] unit;
	} pick_t;

	// The lowest-numbered free unit whose class mask has the entry's class.
	function automatic pick_t pick_unit(input logic [CLASS_W-1:0] cls,
			input logic [UNITS-1:0] free, input logic [UNITS-1:0][MASK_W-1:0] masks);
		pick_t p;
		p = '0;
		for (int u = UNITS - 1; u >= 0; u--) begin
			if (free[u] && masks[u][cls]) begin
				p.hit = 1'b1;
				p.unit = UNIT_W'(u);
			end
		end
		return p;
	endfunction

endpackage

// ----- rtl/rswd_cell.sv -----
// ----------------------------------------------------------------------------
// Reservation station cell
// Holds one entry; wakes its sources, loads on issue, shifts toward the head.
// ----------------------------------------------------------------------------
module rswd_cell import rswd_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     new_entry,
	input  entry_t     next_entry,
	input  entry_t     head_entry,
	output entry_t     entry
);

	entry_t entry_q;
	entry_t woken;

	always_comb begin
		woken = entry_q;
		if (ctrl.wake) begin
			for (int s = 0; s < SRCS; s++) begin
				if (entry_q.wait_mask[s] && (entry_q.wait_tags[s] == ctrl.bus_tag)) begin
					woken.wait_mask[s] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			entry_q <= new_entry;
		end else if (ctrl.take_head) begin
			entry_q <= head_entry;
		end else if (ctrl.shift) begin
			entry_q <= next_entry;
		end else begin
			entry_q <= woken;
		end
	end

	assign entry = entry_q;

endmodule

// ----- rtl/reservation_station_wakeup_dispatch_unit.sv -----
// ----------------------------------------------------------------------------
// Reservation station with tag wakeup and in-order dispatch
// Input items are tick, issue or flush; results are dispatch records and
// issue responses, each marked last on the final result of its item.
//
// An issue transfer stores the entry in the cell after the youngest one and
// its response appears in the output register on the next cycle. A flush
// empties the station at once and gives no result. A tick transfer clears
// every awaited source that matches the broadcast tag, when bus_valid is set,
// in all cells in that cycle, then walks the row: the head cell is examined
// once per cycle unless a stall holds the walk, and either leaves for a unit
// or moves to the tail. A tick on an empty station skips the walk.
// A dispatch record is held in a pending register so that the final one can
// carry last. in_ready is low during a walk and while the output register
// holds a record that the receiver has not taken. When the receiver stalls,
// the output register holds its record and the walk waits before the next
// dispatch. Reset empties the station, sets the limit to eight and every
// class mask to all ones; stored entries need no clearing.
// ----------------------------------------------------------------------------
module reservation_station_wakeup_dispatch_unit import rswd_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic                 bus_valid,
	input  logic [TAG_W-1:0]     bus_tag,
	input  logic [UNITS-1:0]     units_free,
	input  logic [TAG_W-1:0]     new_tag,
	input  logic [CLASS_W-1:0]   new_class,
	input  logic                 src0_valid,
	input  logic [TAG_W-1:0]     src0_tag,
	input  logic                 src1_valid,
	input  logic [TAG_W-1:0]     src1_tag,
	input  logic                 src2_valid,
	input  logic [TAG_W-1:0]     src2_tag,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 kind,
	output logic [UNIT_W-1:0]    unit_index,
	output logic [TAG_W-1:0]     rob_tag,
	output logic                 accepted,
	output logic [OCC_W-1:0]     occupancy,
	output logic                 is_full,
	output logic                 last
);

	localparam int CNT_W = $clog2(ENTRIES + 1);

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] steps_q;
	logic [UNITS-1:0] free_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [UNITS-1:0][MASK_W-1:0] masks_q;

	logic pend_valid_q;
	logic [UNIT_W-1:0] pend_unit_q;
	logic [TAG_W-1:0] pend_tag_q;
	logic [CNT_W-1:0] pend_occ_q;
	logic pend_full_q;

	logic out_valid_q;
	logic kind_q;
	logic [UNIT_W-1:0] unit_q;
	logic [TAG_W-1:0] tag_q;
	logic accepted_q;
	logic [OCC_W-1:0] occ_q;
	logic full_q;
	logic last_q;

	entry_t cells [ENTRIES];
	entry_t nxt [ENTRIES];
	cell_ctrl_t ctrl [ENTRIES];
	entry_t new_entry;
	entry_t head;
	pick_t pick;

	logic [CMP_W-1:0] eff_limit;
	logic can_store;
	logic [CNT_W-1:0] count_inc;
	logic [CNT_W-1:0] count_dec;
	logic [CNT_W-1:0] issue_count;
	logic out_free;
	logic in_xfer;
	logic do_tick;
	logic do_issue;
	logic do_flush;
	logic walking;
	logic hit;
	logic stall;
	logic step;
	logic remove;
	logic rotate;
	logic finish;
	logic out_resp;
	logic out_disp;

	assign eff_limit = (CMP_W'(limit_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(limit_q);
	assign can_store = CMP_W'(count_q) < eff_limit;
	assign count_inc = count_q + 1'b1;
	assign count_dec = count_q - 1'b1;
	assign issue_count = can_store ? count_inc : count_q;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_xfer = in_valid && in_ready;
	assign do_tick = in_xfer && (opcode == OP_TICK);
	assign do_issue = in_xfer && (opcode == OP_ISSUE);
	assign do_flush = in_xfer && (opcode == OP_FLUSH);

	assign head = cells[0];
	assign pick = pick_unit(head.cls, free_q, masks_q);
	assign walking = (state_q == ST_WALK);
	assign hit = walking && (steps_q != '0) && (head.wait_mask == '0) && pick.hit;
	assign stall = hit && pend_valid_q && !out_free;
	assign step = walking && (steps_q != '0) && !stall;
	assign remove = step && hit;
	assign rotate = step && !hit;
	assign finish = walking && (steps_q == '0) && (!pend_valid_q || out_free);
	assign out_resp = do_issue;
	assign out_disp = (remove || finish) && pend_valid_q;

	always_comb begin
		new_entry.rob_tag = new_tag;
		new_entry.cls = new_class;
		new_entry.wait_mask = {src2_valid, src1_valid, src0_valid};
		new_entry.wait_tags = {src2_tag, src1_tag, src0_tag};
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == ENTRIES - 1) begin : g_tail
			assign nxt[i] = cells[0];
		end else begin : g_body
			assign nxt[i] = cells[i+1];
		end

		always_comb begin
			ctrl[i].wake = do_tick && bus_valid;
			ctrl[i].bus_tag = bus_tag;
			ctrl[i].load = do_issue && can_store && (count_q == CNT_W'(i));
			ctrl[i].shift = step;
			ctrl[i].take_head = rotate && (count_dec == CNT_W'(i));
		end

		rswd_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[i]),
			.new_entry  (new_entry),
			.next_entry (nxt[i]),
			.head_entry (head),
			.entry      (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_W'(LIMIT_RESET);
			masks_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_UNIT0: masks_q[0] <= cfg_data;
				CFG_UNIT1: masks_q[1] <= cfg_data;
				CFG_UNIT2: masks_q[2] <= cfg_data;
				CFG_UNIT3: masks_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			steps_q <= '0;
			free_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (do_tick && (count_q != '0)) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (do_tick) begin
				steps_q <= count_q;
				free_q <= units_free;
			end else if (step) begin
				steps_q <= steps_q - 1'b1;
			end
			if (remove) begin
				free_q[pick.unit] <= 1'b0;
			end

			if (do_flush) begin
				count_q <= '0;
			end else if (do_issue && can_store) begin
				count_q <= count_inc;
			end else if (remove) begin
				count_q <= count_dec;
			end

			if (remove) begin
				pend_valid_q <= 1'b1;
			end else if (finish) begin
				pend_valid_q <= 1'b0;
			end

			if (out_resp || out_disp) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (remove) begin
			pend_unit_q <= pick.unit;
			pend_tag_q <= head.rob_tag;
			pend_occ_q <= count_dec;
			pend_full_q <= CMP_W'(count_dec) >= eff_limit;
		end
		if (out_resp) begin
			kind_q <= 1'b1;
			unit_q <= '0;
			tag_q <= '0;
			accepted_q <= can_store;
			occ_q <= OCC_W'(issue_count);
			full_q <= CMP_W'(issue_count) >= eff_limit;
			last_q <= 1'b1;
		end else if (out_disp) begin
			kind_q <= 1'b0;
			unit_q <= pend_unit_q;
			tag_q <= pend_tag_q;
			accepted_q <= 1'b0;
			occ_q <= OCC_W'(pend_occ_q);
			full_q <= pend_full_q;
			last_q <= finish;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign unit_index = unit_q;
	assign rob_tag = tag_q;
	assign accepted = accepted_q;
	assign occupancy = occ_q;
	assign is_full = full_q;
	assign last = last_q;

endmodule

// ----- rtl/rswd_checker.sv -----
// ----------------------------------------------------------------------------
// Reservation station checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "reservation_station_wakeup_dispatch_unit_defines.svh"

module rswd_checker import rswd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic              kind,
	input logic [UNIT_W-1:0] unit_index,
	input logic [TAG_W-1:0]  rob_tag,
	input logic              accepted,
	input logic [OCC_W-1:0]  occupancy,
	input logic              is_full,
	input logic              last
);

	// An issue response is always the only result of its item.
	`RSWD_ASSERT_IMP(a_resp_shape, out_valid && kind, last && (unit_index == '0) && (rob_tag == '0))
	`RSWD_ASSERT_IMP(a_disp_not_acc, out_valid && !kind, !accepted)
	// A rejected issue can only happen on a full station.
	`RSWD_ASSERT_IMP(a_reject_full, out_valid && kind && !accepted, is_full)
	`RSWD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(rob_tag) && $stable(occupancy) && $stable(last))

endmodule

bind reservation_station_wakeup_dispatch_unit rswd_checker u_rswd_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reservation station wakeup and dispatch testbench
// Drives tick, issue and flush transfers through a short table of directed
// cases and then random phases under several limit and class mask settings.
// A local model of the station predicts every dispatch record and issue
// response, and each output transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import rswd_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 2 * ENTRIES_DEF + 8;
	localparam int PHASE_ITEMS = 44;

	typedef struct packed {
		logic [1:0] op;
		logic bus_valid;
		logic [TAG_W-1:0] bus_tag;
		logic [UNITS-1:0] units_free;
		logic [TAG_W-1:0] new_tag;
		logic [CLASS_W-1:0] new_class;
		logic [SRCS-1:0] src_valid;
		logic [SRCS-1:0][TAG_W-1:0] src_tag;
	} station_item_t;

	typedef struct packed {
		logic kind;
		logic [UNIT_W-1:0] unit;
		logic [TAG_W-1:0] tag;
		logic acc;
		logic [OCC_W-1:0] occ;
		logic full;
		logic last;
	} station_record_t;

	typedef struct packed {
		logic [TAG_W-1:0] rob_tag;
		logic [CLASS_W-1:0] cls;
		logic [SRCS-1:0] wait_mask;
		logic [SRCS-1:0][TAG_W-1:0] wait_tags;
	} held_entry_t;

	typedef struct packed {
		station_item_t item;
		bit typed;
		station_record_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] opcode;
	logic bus_valid;
	logic [TAG_W-1:0] bus_tag;
	logic [UNITS-1:0] units_free;
	logic [TAG_W-1:0] new_tag;
	logic [CLASS_W-1:0] new_class;
	logic src0_valid;
	logic [TAG_W-1:0] src0_tag;
	logic src1_valid;
	logic [TAG_W-1:0] src1_tag;
	logic src2_valid;
	logic [TAG_W-1:0] src2_tag;
	logic out_valid;
	logic out_ready;
	logic kind;
	logic [UNIT_W-1:0] unit_index;
	logic [TAG_W-1:0] rob_tag;
	logic accepted;
	logic [OCC_W-1:0] occupancy;
	logic is_full;
	logic last;

	logic [LIMIT_W-1:0] limit_reg;
	logic [UNITS-1:0][MASK_W-1:0] unit_masks;
	held_entry_t station_entries[$];
	station_record_t expected_records[$];
	int mismatch_count;
	bit calm;

	reservation_station_wakeup_dispatch_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.bus_valid(bus_valid),
		.bus_tag(bus_tag),
		.units_free(units_free),
		.new_tag(new_tag),
		.new_class(new_class),
		.src0_valid(src0_valid),
		.src0_tag(src0_tag),
		.src1_valid(src1_valid),
		.src1_tag(src1_tag),
		.src2_valid(src2_valid),
		.src2_tag(src2_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.unit_index(unit_index),
		.rob_tag(rob_tag),
		.accepted(accepted),
		.occupancy(occupancy),
		.is_full(is_full),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= calm || ($urandom_range(0, 99) >= 16);
		end
	end

	function automatic station_item_t tick_item(input logic bv, input logic [TAG_W-1:0] bt,
			input logic [UNITS-1:0] free);
		station_item_t it;
		it = '0;
		it.op = OP_TICK;
		it.bus_valid = bv;
		it.bus_tag = bt;
		it.units_free = free;
		return it;
	endfunction

	function automatic station_item_t issue_item(input logic [TAG_W-1:0] tag,
			input logic [CLASS_W-1:0] cls, input logic [SRCS-1:0] sv,
			input logic [TAG_W-1:0] t0, input logic [TAG_W-1:0] t1, input logic [TAG_W-1:0] t2);
		station_item_t it;
		it = '0;
		it.op = OP_ISSUE;
		it.new_tag = tag;
		it.new_class = cls;
		it.src_valid = sv;
		it.src_tag = {t2, t1, t0};
		return it;
	endfunction

	function automatic station_item_t plain_item(input logic [1:0] op, input bit ones);
		station_item_t it;
		it = ones ? '1 : '0;
		it.op = op;
		return it;
	endfunction

	function automatic station_record_t issue_resp(input logic acc, input int occ, input logic full);
		return {1'b1, {UNIT_W{1'b0}}, {TAG_W{1'b0}}, acc, OCC_W'(occ), full, 1'b1};
	endfunction

	function automatic station_item_t random_item();
		station_item_t it;
		int pick;
		int e;
		it.bus_valid = ($urandom_range(0, 99) < 80);
		it.bus_tag = TAG_W'($urandom_range(0, 63));
		it.units_free = UNITS'($urandom_range(0, 15));
		it.new_tag = TAG_W'($urandom_range(0, 63));
		it.new_class = CLASS_W'($urandom_range(0, 7));
		it.src_valid = SRCS'($urandom_range(0, 7));
		for (int s = 0; s < SRCS; s++)
			it.src_tag[s] = TAG_W'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 7) :
				$urandom_range(0, 63));
		if (station_entries.size() > 0 && $urandom_range(0, 99) < 70) begin
			e = $urandom_range(0, station_entries.size() - 1);
			it.bus_tag = station_entries[e].wait_tags[$urandom_range(0, SRCS - 1)];
		end
		pick = $urandom_range(0, 99);
		if (pick < 46)
			it.op = OP_ISSUE;
		else if (pick < 90)
			it.op = OP_TICK;
		else if (pick < 95)
			it.op = OP_FLUSH;
		else
			it.op = OP_NONE;
		return it;
	endfunction

	task automatic station_step(input station_item_t it);
		logic [UNITS-1:0] free;
		held_entry_t e;
		station_record_t r;
		int cap;
		int i;
		int n;
		bit sent;
		logic acc;
		cap = (limit_reg > ENTRIES_DEF) ? ENTRIES_DEF : int'(limit_reg);
		n = 0;
		case (it.op)
			OP_TICK: begin
				if (it.bus_valid) begin
					for (int k = 0; k < station_entries.size(); k++) begin
						e = station_entries[k];
						for (int s = 0; s < SRCS; s++)
							if (e.wait_mask[s] && e.wait_tags[s] == it.bus_tag)
								e.wait_mask[s] = 1'b0;
						station_entries[k] = e;
					end
				end
				free = it.units_free;
				i = 0;
				while (i < station_entries.size()) begin
					sent = 1'b0;
					e = station_entries[i];
					if (e.wait_mask == '0) begin
						for (int u = 0; u < UNITS && !sent; u++) begin
							if (free[u] && unit_masks[u][e.cls]) begin
								free[u] = 1'b0;
								station_entries.delete(i);
								r = {1'b0, UNIT_W'(u), e.rob_tag, 1'b0,
									OCC_W'(station_entries.size()),
									station_entries.size() >= cap, 1'b0};
								expected_records.insert(expected_records.size(), r);
								n++;
								sent = 1'b1;
							end
						end
					end
					if (!sent)
						i++;
				end
				if (n > 0)
					expected_records[expected_records.size() - 1].last = 1'b1;
			end
			OP_ISSUE: begin
				acc = (station_entries.size() < cap);
				if (acc) begin
					e.rob_tag = it.new_tag;
					e.cls = it.new_class;
					e.wait_mask = it.src_valid;
					for (int s = 0; s < SRCS; s++)
						e.wait_tags[s] = it.src_valid[s] ? it.src_tag[s] : '0;
					station_entries.insert(station_entries.size(), e);
				end
				expected_records.insert(expected_records.size(),
					issue_resp(acc, station_entries.size(), station_entries.size() >= cap));
			end
			OP_FLUSH: station_entries.delete();
			default: ;
		endcase
	endtask

	task automatic send(input station_item_t it);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 16)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode <= it.op;
		bus_valid <= it.bus_valid;
		bus_tag <= it.bus_tag;
		units_free <= it.units_free;
		new_tag <= it.new_tag;
		new_class <= it.new_class;
		src0_valid <= it.src_valid[0];
		src0_tag <= it.src_tag[0];
		src1_valid <= it.src_valid[1];
		src1_tag <= it.src_tag[1];
		src2_valid <= it.src_valid[2];
		src2_tag <= it.src_tag[2];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		station_step(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [LIMIT_W-1:0] lim,
			input logic [UNITS-1:0][MASK_W-1:0] masks);
		cfg_we <= 1'b1;
		cfg_index <= CFG_LIMIT;
		cfg_data <= CFG_W'(lim);
		@(posedge clk);
		cfg_index <= CFG_UNIT0;
		cfg_data <= masks[0];
		@(posedge clk);
		cfg_index <= CFG_UNIT1;
		cfg_data <= masks[1];
		@(posedge clk);
		cfg_index <= CFG_UNIT2;
		cfg_data <= masks[2];
		@(posedge clk);
		cfg_index <= CFG_UNIT3;
		cfg_data <= masks[3];
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = lim;
		unit_masks = masks;
	endtask

	always @(posedge clk) begin
		station_record_t got;
		station_record_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {kind, unit_index, rob_tag, accepted, occupancy, is_full, last};
			if (expected_records.size() == 0) begin
				if (mismatch_count < 10)
					$display("tb: unexpected transfer kind %0d unit %0d tag %0d acc %0d occ %0d full %0d last %0d",
						got.kind, got.unit, got.tag, got.acc, got.occ, got.full, got.last);
				mismatch_count++;
			end else begin
				want = expected_records.pop_front();
				if (got !== want) begin
					if (mismatch_count < 10) begin
						$display("tb: mismatch got  kind %0d unit %0d tag %0d acc %0d occ %0d full %0d last %0d",
							got.kind, got.unit, got.tag, got.acc, got.occ, got.full, got.last);
						$display("tb:      expected kind %0d unit %0d tag %0d acc %0d occ %0d full %0d last %0d",
							want.kind, want.unit, want.tag, want.acc, want.occ, want.full, want.last);
					end
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		plan_row_t plan[$];
		logic [UNITS-1:0][MASK_W-1:0] masks;
		logic [LIMIT_W-1:0] lim;
		mismatch_count = 0;
		calm = 1'b0;
		limit_reg = LIMIT_W'(LIMIT_RESET);
		unit_masks = '1;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		opcode <= OP_TICK;
		bus_valid <= 1'b0;
		bus_tag <= '0;
		units_free <= '0;
		new_tag <= '0;
		new_class <= '0;
		src0_valid <= 1'b0;
		src0_tag <= '0;
		src1_valid <= 1'b0;
		src1_tag <= '0;
		src2_valid <= 1'b0;
		src2_tag <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.insert(plan.size(), '{issue_item(6'd0, 3'd0, 3'b000, 6'd0, 6'd0, 6'd0), 1'b1,
			issue_resp(1'b1, 1, 1'b0)});
		plan.insert(plan.size(), '{tick_item(1'b0, 6'd0, 4'b0000), 1'b0, '0});
		plan.insert(plan.size(), '{tick_item(1'b0, 6'd0, 4'b1000), 1'b0, '0});
		plan.insert(plan.size(), '{issue_item(6'd63, 3'd7, 3'b111, 6'd63, 6'd63, 6'd0), 1'b1,
			issue_resp(1'b1, 1, 1'b0)});
		plan.insert(plan.size(), '{issue_item(6'd21, 3'd5, 3'b011, 6'd42, 6'd21, 6'd63), 1'b1,
			issue_resp(1'b1, 2, 1'b0)});
		plan.insert(plan.size(), '{tick_item(1'b1, 6'd63, 4'b1111), 1'b0, '0});
		plan.insert(plan.size(), '{tick_item(1'b1, 6'd0, 4'b1111), 1'b0, '0});
		plan.insert(plan.size(), '{plain_item(OP_NONE, 1'b1), 1'b0, '0});
		plan.insert(plan.size(), '{tick_item(1'b1, 6'd42, 4'b1111), 1'b0, '0});
		plan.insert(plan.size(), '{tick_item(1'b1, 6'd21, 4'b0110), 1'b0, '0});
		for (int k = 1; k <= ENTRIES_DEF; k++)
			plan.insert(plan.size(),
				'{issue_item(TAG_W'(k), CLASS_W'(k - 1), 3'b000, 6'd0, 6'd0, 6'd0),
				1'b1, issue_resp(1'b1, k, k == ENTRIES_DEF)});
		plan.insert(plan.size(), '{issue_item(6'd50, 3'd2, 3'b000, 6'd0, 6'd0, 6'd0), 1'b1,
			issue_resp(1'b0, ENTRIES_DEF, 1'b1)});
		plan.insert(plan.size(), '{tick_item(1'b0, 6'd0, 4'b1111), 1'b0, '0});
		plan.insert(plan.size(), '{tick_item(1'b0, 6'd0, 4'b1111), 1'b0, '0});
		plan.insert(plan.size(), '{issue_item(6'd9, 3'd3, 3'b100, 6'd0, 6'd0, 6'd33), 1'b1,
			issue_resp(1'b1, 1, 1'b0)});
		plan.insert(plan.size(), '{plain_item(OP_FLUSH, 1'b0), 1'b0, '0});
		plan.insert(plan.size(), '{tick_item(1'b1, 6'd33, 4'b1111), 1'b0, '0});

		foreach (plan[k]) begin
			send(plan[k].item);
			if (plan[k].typed)
				expected_records[expected_records.size() - 1] = plan[k].want;
		end
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			calm = (phase == 1);
			case (phase)
				0: begin
					lim = 4'd8;
					masks = '1;
				end
				1: begin
					lim = 4'd1;
					masks = {8'h08, 8'h04, 8'h02, 8'h01};
				end
				2: begin
					lim = 4'd15;
					masks = '0;
				end
				3: begin
					lim = 4'd0;
					masks = {8'haa, 8'h00, 8'hff, 8'h80};
				end
				4: begin
					lim = 4'd4;
					masks = {8'hc3, 8'h3c, 8'hf0, 8'h0f};
				end
				default: begin
					lim = LIMIT_W'($urandom_range(1, 8));
					for (int u = 0; u < UNITS; u++)
						masks[u] = MASK_W'($urandom_range(0, 255));
				end
			endcase
			configure(lim, masks);
			repeat (PHASE_ITEMS) send(random_item());
			drain();
		end
		calm = 1'b0;

		if (mismatch_count == 0 && expected_records.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
